// ===== rtl/core/kci_pkg.sv =====
package kci_pkg;

	localparam int KCI_KEYS   = 32;
	localparam int KCI_IDX_W  = $clog2(KCI_KEYS);
	localparam int KCI_CNT_W  = KCI_IDX_W + 1;
	localparam int KCI_VAL_W  = 24;
	localparam int KCI_FRAC_W = 16;
	localparam int KCI_PROD_W = KCI_VAL_W + KCI_FRAC_W;

	localparam logic [1:0] CASE_INTERP = 2'd0;
	localparam logic [1:0] CASE_BEFORE = 2'd1;
	localparam logic [1:0] CASE_AFTER  = 2'd2;
	localparam logic [1:0] CASE_EQUAL  = 2'd3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                 vld;
		logic                 found;
		logic [1:0]           code;
		logic [KCI_CNT_W-1:0] pos;
		logic [KCI_IDX_W-1:0] lo_idx;
		logic [KCI_VAL_W-1:0] q;
		logic [KCI_VAL_W-1:0] lo_t;
		logic [KCI_VAL_W-1:0] lo_x;
		logic [KCI_VAL_W-1:0] lo_y;
		logic [KCI_VAL_W-1:0] lo_z;
		logic [KCI_VAL_W-1:0] hi_t;
		logic [KCI_VAL_W-1:0] hi_x;
		logic [KCI_VAL_W-1:0] hi_y;
		logic [KCI_VAL_W-1:0] hi_z;
	} kci_tok_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIV,
		ST_BLEND,
		ST_OUT
	} kci_state_t;

endpackage

// ===== rtl/core/kci_cell.sv =====
module kci_cell import kci_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [KCI_VAL_W-1:0] wr_t,
	input  logic [KCI_VAL_W-1:0] wr_x,
	input  logic [KCI_VAL_W-1:0] wr_y,
	input  logic [KCI_VAL_W-1:0] wr_z,
	input  logic [KCI_CNT_W-1:0] n,
	input  kci_tok_t             tok_in,
	output kci_tok_t             tok_out
);

	logic [KCI_VAL_W-1:0] t_q, x_q, y_q, z_q;
	kci_tok_t             nxt;
	kci_tok_t             tok_q;
	logic                 vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			t_q <= wr_t;
			x_q <= wr_x;
			y_q <= wr_y;
			z_q <= wr_z;
		end
	end

	always_comb begin
		nxt = tok_in;
		nxt.pos = tok_in.pos + 1'b1;
		if (tok_in.vld && !tok_in.found && tok_in.pos < n) begin
			if (t_q > tok_in.q) begin
				nxt.found = 1'b1;
				nxt.hi_t = t_q;
				nxt.hi_x = x_q;
				nxt.hi_y = y_q;
				nxt.hi_z = z_q;
				if (tok_in.pos == '0) begin
					nxt.code = CASE_BEFORE;
					nxt.lo_idx = '0;
					nxt.lo_t = t_q;
					nxt.lo_x = x_q;
					nxt.lo_y = y_q;
					nxt.lo_z = z_q;
				end else begin
					nxt.code = (tok_in.lo_t == t_q) ? CASE_EQUAL : CASE_INTERP;
				end
			end else begin
				nxt.lo_idx = tok_in.pos[KCI_IDX_W-1:0];
				nxt.lo_t = t_q;
				nxt.lo_x = x_q;
				nxt.lo_y = y_q;
				nxt.lo_z = z_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
	end

	always_comb begin
		tok_out = tok_q;
		tok_out.vld = vld_q;
	end

endmodule

// ===== rtl/core/kci_div.sv =====
module kci_div import kci_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [KCI_VAL_W-1:0]  rem_init,
	input  logic [KCI_VAL_W-1:0]  den,
	output logic                  done,
	output logic [KCI_FRAC_W-1:0] quot
);

	localparam int CW = $clog2(KCI_FRAC_W);

	logic                  run_q, done_q;
	logic [CW-1:0]         cnt_q;
	logic [KCI_VAL_W-1:0]  rem_q, den_q;
	logic [KCI_FRAC_W-1:0] quot_q;
	logic [KCI_VAL_W:0]    trial;
	logic                  ge;

	assign trial = {rem_q, 1'b0};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(KCI_FRAC_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? KCI_VAL_W'(trial - {1'b0, den_q}) : trial[KCI_VAL_W-1:0];
			quot_q <= {quot_q[KCI_FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/core/keyframe_color_interpolator_unit.sv =====
// A query's result word comes out after the key chain when it is a clamped or equal key,
// and after the divider and the blend as well when it is interpolated. The next item is
// accepted once the result word is shown; a load leaves the unit idle and returns nothing.
// The query token walks a chain of 32 key cells, one per cycle, then a 16-step divider
// and a shared multiplier that blends one channel per cycle. One query is in flight.
// Reset clears the control state and sets key_count to 1; the key table holds garbage
// until it is loaded. The receiver cannot stall; each result word is shown for one cycle.
module keyframe_color_interpolator_unit import kci_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [KCI_IDX_W-1:0] entry_index,
	input  logic [KCI_VAL_W-1:0] key_time,
	input  logic [KCI_VAL_W-1:0] key_x,
	input  logic [KCI_VAL_W-1:0] key_y,
	input  logic [KCI_VAL_W-1:0] key_z,
	input  logic [KCI_VAL_W-1:0] query_time,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [5:0]           cfg_data,
	output logic                 strobe,
	output logic [KCI_VAL_W-1:0] value_x,
	output logic [KCI_VAL_W-1:0] value_y,
	output logic [KCI_VAL_W-1:0] value_z,
	output logic [1:0]           case_code,
	output logic [KCI_IDX_W-1:0] segment_start
);

	kci_state_t state_q, state_nxt;
	logic [5:0]           key_count_q;
	logic [KCI_CNT_W-1:0] n_eff;
	logic                 accept;
	kci_tok_t             head;
	kci_tok_t             chain [0:KCI_KEYS];
	kci_tok_t             res_q;
	logic                 div_start, div_done;
	logic [KCI_FRAC_W-1:0] div_quot, frac_q;
	logic [1:0]           mc_q;
	logic [KCI_VAL_W-1:0] lo_sel, hi_sel, lo_s1;
	logic                 dir_s1;
	logic [KCI_PROD_W-1:0] prod_s1;
	logic [KCI_PROD_W:0]  prod_up;
	logic [KCI_VAL_W-1:0] blend_val;
	logic [KCI_VAL_W-1:0] vx_q, vy_q, vz_q;
	logic [1:0]           code_q;
	logic [KCI_IDX_W-1:0] seg_q;

	assign cfg_ready = !busy;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 6'd1;
		end else if (cfg_valid && cfg_ready) begin
			key_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (key_count_q == '0) begin
			n_eff = KCI_CNT_W'(1);
		end else if (32'(key_count_q) > KCI_KEYS) begin
			n_eff = KCI_CNT_W'(KCI_KEYS);
		end else begin
			n_eff = KCI_CNT_W'(key_count_q);
		end
	end

	always_comb begin
		head = '0;
		head.vld = accept && (op == OP_QUERY);
		head.code = CASE_AFTER;
		head.q = query_time;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < KCI_KEYS; i++) begin : g_cell
		kci_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.we      (accept && op == OP_LOAD && entry_index == KCI_IDX_W'(i)),
			.wr_t    (key_time),
			.wr_x    (key_x),
			.wr_y    (key_y),
			.wr_z    (key_z),
			.n       (n_eff),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	kci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (chain[KCI_KEYS].q - chain[KCI_KEYS].lo_t),
		.den      (chain[KCI_KEYS].hi_t - chain[KCI_KEYS].lo_t),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_QUERY) state_nxt = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (chain[KCI_KEYS].vld) begin
					state_nxt = (chain[KCI_KEYS].code == CASE_INTERP) ? ST_DIV : ST_OUT;
				end
			end
			ST_DIV: begin
				if (div_done) state_nxt = ST_BLEND;
			end
			ST_BLEND: begin
				if (mc_q == 2'd3) state_nxt = ST_OUT;
			end
			ST_OUT: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != ST_IDLE;
		strobe = state_q == ST_OUT;
		div_start = state_q == ST_SEARCH && chain[KCI_KEYS].vld
			&& chain[KCI_KEYS].code == CASE_INTERP;
	end

	always_comb begin
		case (mc_q)
			2'd0: begin
				lo_sel = res_q.lo_x;
				hi_sel = res_q.hi_x;
			end
			2'd1: begin
				lo_sel = res_q.lo_y;
				hi_sel = res_q.hi_y;
			end
			default: begin
				lo_sel = res_q.lo_z;
				hi_sel = res_q.hi_z;
			end
		endcase
	end

	// A falling step rounds toward minus infinity, so its magnitude is rounded up.
	always_comb begin
		prod_up = {1'b0, prod_s1} + (KCI_PROD_W+1)'({KCI_FRAC_W{1'b1}});
		if (dir_s1) begin
			blend_val = lo_s1 + prod_s1[KCI_PROD_W-1:KCI_FRAC_W];
		end else begin
			blend_val = lo_s1 - prod_up[KCI_PROD_W-1:KCI_FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q <= '0;
		end else if (state_q == ST_BLEND) begin
			mc_q <= mc_q + 1'b1;
		end else begin
			mc_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEARCH && chain[KCI_KEYS].vld) begin
			res_q <= chain[KCI_KEYS];
			vx_q <= chain[KCI_KEYS].lo_x;
			vy_q <= chain[KCI_KEYS].lo_y;
			vz_q <= chain[KCI_KEYS].lo_z;
			code_q <= chain[KCI_KEYS].code;
			seg_q <= chain[KCI_KEYS].lo_idx;
		end
		if (div_done) begin
			frac_q <= div_quot;
		end
		if (state_q == ST_BLEND) begin
			dir_s1 <= hi_sel >= lo_sel;
			lo_s1 <= lo_sel;
			prod_s1 <= (hi_sel >= lo_sel ? hi_sel - lo_sel : lo_sel - hi_sel) * frac_q;
			case (mc_q)
				2'd1: vx_q <= blend_val;
				2'd2: vy_q <= blend_val;
				2'd3: vz_q <= blend_val;
				default: ;
			endcase
		end
	end

	assign value_x = vx_q;
	assign value_y = vy_q;
	assign value_z = vz_q;
	assign case_code = code_q;
	assign segment_start = seg_q;

endmodule

// ===== verif/keyframe_color_interpolator_unit_tb.sv =====
module keyframe_color_interpolator_unit_tb;
	import kci_pkg::*;

	typedef struct {
		logic [KCI_VAL_W-1:0] vx;
		logic [KCI_VAL_W-1:0] vy;
		logic [KCI_VAL_W-1:0] vz;
		logic [1:0]           code;
		logic [KCI_IDX_W-1:0] seg;
	} color_t;

	class color_scoreboard;
		logic [KCI_VAL_W-1:0] t_tab[KCI_KEYS];
		logic [KCI_VAL_W-1:0] x_tab[KCI_KEYS];
		logic [KCI_VAL_W-1:0] y_tab[KCI_KEYS];
		logic [KCI_VAL_W-1:0] z_tab[KCI_KEYS];
		int unsigned count_reg;
		color_t pending[$];
		int errors;

		function new();
			count_reg = 1;
			errors = 0;
		endfunction

		function logic [KCI_VAL_W-1:0] mix(logic [KCI_VAL_W-1:0] lo,
				logic [KCI_VAL_W-1:0] hi, longint unsigned frac);
			longint unsigned prod;
			if (hi >= lo) begin
				prod = longint'(hi - lo) * frac;
				return lo + KCI_VAL_W'(prod >> KCI_FRAC_W);
			end
			prod = longint'(lo - hi) * frac;
			prod = (prod + (64'd1 << KCI_FRAC_W) - 1) >> KCI_FRAC_W;
			return lo - KCI_VAL_W'(prod);
		endfunction

		function void note_item(logic o, int idx, logic [KCI_VAL_W-1:0] kt,
				logic [KCI_VAL_W-1:0] kx, logic [KCI_VAL_W-1:0] ky,
				logic [KCI_VAL_W-1:0] kz, logic [KCI_VAL_W-1:0] q);
			int n;
			int up;
			int lo;
			longint unsigned frac;
			color_t c;
			if (o == OP_LOAD) begin
				t_tab[idx] = kt;
				x_tab[idx] = kx;
				y_tab[idx] = ky;
				z_tab[idx] = kz;
				return;
			end
			n = count_reg == 0 ? 1 : (count_reg > KCI_KEYS ? KCI_KEYS : count_reg);
			up = n;
			for (int i = 0; i < n; i++) begin
				if (t_tab[i] > q) begin
					up = i;
					break;
				end
			end
			lo = (up == 0) ? 0 : (up == n ? n - 1 : up - 1);
			c.vx = x_tab[lo];
			c.vy = y_tab[lo];
			c.vz = z_tab[lo];
			c.seg = KCI_IDX_W'(lo);
			if (up == 0) c.code = CASE_BEFORE;
			else if (up == n) c.code = CASE_AFTER;
			else if (t_tab[lo] == t_tab[up] || t_tab[lo] > q) c.code = CASE_EQUAL;
			else begin
				frac = (longint'(q - t_tab[lo]) << KCI_FRAC_W) / longint'(t_tab[up] - t_tab[lo]);
				c.vx = mix(x_tab[lo], x_tab[up], frac);
				c.vy = mix(y_tab[lo], y_tab[up], frac);
				c.vz = mix(z_tab[lo], z_tab[up], frac);
				c.code = CASE_INTERP;
			end
			pending.push_back(c);
		endfunction

		function void check_color(color_t got);
			color_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h", $time, got.vx, got.vy, got.vz);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.vx !== e.vx) begin
				$display("%0t: value_x expected %h actual %h", $time, e.vx, got.vx);
				errors++;
			end
			if (got.vy !== e.vy) begin
				$display("%0t: value_y expected %h actual %h", $time, e.vy, got.vy);
				errors++;
			end
			if (got.vz !== e.vz) begin
				$display("%0t: value_z expected %h actual %h", $time, e.vz, got.vz);
				errors++;
			end
			if (got.code !== e.code) begin
				$display("%0t: case_code expected %0d actual %0d", $time, e.code, got.code);
				errors++;
			end
			if (got.seg !== e.seg) begin
				$display("%0t: segment_start expected %0d actual %0d", $time, e.seg, got.seg);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = OP_LOAD;
	logic [KCI_IDX_W-1:0] entry_index = '0;
	logic [KCI_VAL_W-1:0] key_time = '0;
	logic [KCI_VAL_W-1:0] key_x = '0;
	logic [KCI_VAL_W-1:0] key_y = '0;
	logic [KCI_VAL_W-1:0] key_z = '0;
	logic [KCI_VAL_W-1:0] query_time = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [5:0] cfg_data = '0;
	logic strobe;
	logic [KCI_VAL_W-1:0] value_x;
	logic [KCI_VAL_W-1:0] value_y;
	logic [KCI_VAL_W-1:0] value_z;
	logic [1:0] case_code;
	logic [KCI_IDX_W-1:0] segment_start;

	color_scoreboard board = new();
	int gap_pct;
	int stall_cycles;
	int written;

	keyframe_color_interpolator_unit DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		color_t got;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (start && !busy) begin
				board.note_item(op, entry_index, key_time, key_x, key_y, key_z, query_time);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) moved = 1'b1;
			if (strobe) begin
				got.vx = value_x;
				got.vy = value_y;
				got.vz = value_z;
				got.code = case_code;
				got.seg = segment_start;
				board.check_color(got);
				moved = 1'b1;
			end
			if (moved) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles > 5000) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// The start line stays high after a word is taken until the next word or an idle
	// cycle replaces it; drain drops it.
	task automatic send_item(logic o, int idx, logic [KCI_VAL_W-1:0] kt,
			logic [KCI_VAL_W-1:0] kx, logic [KCI_VAL_W-1:0] ky,
			logic [KCI_VAL_W-1:0] kz, logic [KCI_VAL_W-1:0] q);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		op <= o;
		entry_index <= KCI_IDX_W'(idx);
		key_time <= kt;
		key_x <= kx;
		key_y <= ky;
		key_z <= kz;
		query_time <= q;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (o == OP_LOAD && idx >= written) written = idx + 1;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_count(int n);
		drain();
		cfg_data <= 6'(n);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.count_reg = n;
	endtask

	// Loads slots 0..n-1 with ascending times; some neighbors share a time.
	task automatic load_table(int n, int step_max);
		logic [KCI_VAL_W-1:0] t;
		t = $urandom_range(3) == 0 ? 0 : $urandom_range(step_max);
		for (int i = 0; i < n; i++) begin
			send_item(OP_LOAD, i, t, $urandom, $urandom, $urandom, $urandom);
			if ($urandom_range(7) != 0 && t < 24'hFFFFFF - step_max)
				t = t + 1 + $urandom_range(step_max);
		end
	endtask

	task automatic query_near(int n);
		int k;
		logic [KCI_VAL_W-1:0] q;
		k = $urandom_range(n - 1);
		case ($urandom_range(4))
			0: q = board.t_tab[k];
			1: q = board.t_tab[k] - 1;
			2: q = board.t_tab[k] + $urandom_range(3);
			3: q = $urandom;
			default: q = board.t_tab[k] + $urandom_range(4000);
		endcase
		send_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, q);
	endtask

	initial begin
		int n;
		gap_pct = 0;
		stall_cycles = 0;
		written = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_LOAD, 0, 24'h000100, 24'hFFFFFF, 24'h000000, 24'h123456, 0);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h000000);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'hFFFFFF);
		send_item(OP_LOAD, 1, 24'h000300, 24'h000000, 24'hFFFFFF, 24'h123456, 0);
		send_item(OP_LOAD, 2, 24'h000300, 24'h000010, 24'h000020, 24'h000030, 0);
		send_item(OP_LOAD, 31, 24'hFFFFFF, 24'hABCDEF, 24'h000001, 24'hFFFFFE, 0);
		write_count(2);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h0000FF);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h000100);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h000155);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h0002FF);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h000300);
		write_count(3);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h000200);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h000300);
		for (int i = 3; i < 31; i++)
			send_item(OP_LOAD, i, 24'h000300 + i, $urandom, $urandom, $urandom, 0);
		write_count(32);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'hFFFFFE);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'hFFFFFF);
		write_count(0);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h000050);
		write_count(63);
		send_item(OP_QUERY, 0, 0, 0, 0, 0, 24'h000310);

		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = ph == 0 ? 26 : (ph == 1 ? 59 : 0);
			for (int r = 0; r < 6; r++) begin
				n = (r % 5 == 0) ? 32 : $urandom_range(1, 8);
				write_count(n);
				load_table(n, r % 2 ? 24'h3FFFFF : 24'h1FF);
				for (int j = 0; j < 8; j++) query_near(n);
			end
		end
		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ===== keyframe_color_interpolator_unit.f =====
rtl/core/kci_pkg.sv
rtl/core/kci_cell.sv
rtl/core/kci_div.sv
rtl/core/keyframe_color_interpolator_unit.sv
verif/keyframe_color_interpolator_unit_tb.sv
